// File: hw/rtl/acfs_pkg.sv
// acfs_pkg: shared types, codes and saturating helpers for the acl credit
// fragment scheduler
// no dependencies
`timescale 1ns / 1ps

package acfs_pkg;

    // default sizing
    localparam int P_MAX_CONNECTIONS = 16;
    localparam int P_QUEUE_DEPTH     = 32;
    localparam int P_MAX_FRAGMENTS   = 32;

    // one item releases at most this many queued fragments
    localparam logic [5:0] DRAIN_MAX = 6'd63;

    // input actions
    localparam logic [1:0] ACT_CONNECT    = 2'd0;
    localparam logic [1:0] ACT_SEND       = 2'd1;
    localparam logic [1:0] ACT_COMPLETE   = 2'd2;
    localparam logic [1:0] ACT_DISCONNECT = 2'd3;

    // result kinds
    localparam logic KIND_FRAG   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // packet boundary flags
    localparam logic [1:0] PB_FIRST_NF = 2'd0;
    localparam logic [1:0] PB_CONT     = 2'd1;
    localparam logic [1:0] PB_FIRST_FL = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_UNKNOWN    = 3'd1;
    localparam logic [2:0] ST_ZERO_FRAME = 3'd2;
    localparam logic [2:0] ST_QUEUE_OVF  = 3'd3;
    localparam logic [2:0] ST_TABLE_FULL = 3'd4;
    localparam logic [2:0] ST_TOO_MANY   = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_ACL_FRAME = 2'd0;
    localparam logic [1:0] REG_ACL_TOTAL = 2'd1;
    localparam logic [1:0] REG_LE_FRAME  = 2'd2;
    localparam logic [1:0] REG_LE_TOTAL  = 2'd3;

    typedef struct packed {
        logic [11:0] handle;
        logic        transport;
        logic [15:0] outstanding;
    } t_conn;

    typedef struct packed {
        logic [11:0] handle;
        logic [1:0]  pb;
        logic [15:0] len;
    } t_frag;

    // add with saturation at 65535
    function automatic logic [15:0] f_add16_sat(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    // add with saturation at 255
    function automatic logic [7:0] f_add8_sat(input logic [7:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {9'd0, a} + {1'b0, b};
        return (s > 17'd255) ? 8'hFF : s[7:0];
    endfunction

endpackage

// File: hw/rtl/acfs_conn_mem.sv
// acfs_conn_mem: connection table storage, one write and one read port,
// registered read data; depends on acfs_pkg
`timescale 1ns / 1ps

module acfs_conn_mem #(
    parameter int DEPTH = acfs_pkg::P_MAX_CONNECTIONS,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  acfs_pkg::t_conn i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output acfs_pkg::t_conn o_rdata
);
    import acfs_pkg::*;

    t_conn r_mem [DEPTH];
    t_conn r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/acfs_queue_mem.sv
// acfs_queue_mem: pending fragment storage for both pools, indexed by pool
// and ring slot; registered read data; depends on acfs_pkg
`timescale 1ns / 1ps

module acfs_queue_mem #(
    parameter int DEPTH = acfs_pkg::P_QUEUE_DEPTH,
    parameter int PW    = 5,
    parameter int SW    = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic            i_wpool,
    input  logic [PW-1:0]   i_wptr,
    input  acfs_pkg::t_frag i_wfrag,
    input  logic [SW-1:0]   i_wslot,
    input  logic            i_re,
    input  logic            i_rpool,
    input  logic [PW-1:0]   i_rptr,
    output acfs_pkg::t_frag o_rfrag,
    output logic [SW-1:0]   o_rslot
);
    import acfs_pkg::*;

    t_frag             r_frag [2][DEPTH];
    logic [SW-1:0]     r_slot [2][DEPTH];
    t_frag             r_rfrag;
    logic [SW-1:0]     r_rslot;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_frag[i_wpool][i_wptr] <= i_wfrag;
            r_slot[i_wpool][i_wptr] <= i_wslot;
        end
        if (i_re) begin
            r_rfrag <= r_frag[i_rpool][i_rptr];
            r_rslot <= r_slot[i_rpool][i_rptr];
        end
    end

    assign o_rfrag = r_rfrag;
    assign o_rslot = r_rslot;

endmodule

// File: hw/rtl/acl_credit_fragment_scheduler.sv
// acl_credit_fragment_scheduler: top level with sequencer, credit pools,
// queue pointers and result register; depends on acfs_pkg, acfs_conn_mem, acfs_queue_mem
// every item starts with a table scan, which ends early only on a matching handle
// send: scan, repeated subtraction, then one fragment per cycle unless the output stalls
// completion: scan, then a queue read, table read and update per drained fragment
// disconnect: scan, then a purge pass over the queued entries of each pool; one item at a time
// reset (synchronous, active low) clears table valid bits, credits, queue pointers, configuration registers and state
`timescale 1ns / 1ps

module acl_credit_fragment_scheduler #(
    parameter int MAX_CONNECTIONS = acfs_pkg::P_MAX_CONNECTIONS,
    parameter int QUEUE_DEPTH     = acfs_pkg::P_QUEUE_DEPTH,
    parameter int MAX_FRAGMENTS   = acfs_pkg::P_MAX_FRAGMENTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // input beat
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [11:0] i_handle,
    input  logic        i_transport,
    input  logic [15:0] i_payload_length,
    input  logic        i_flushable,
    input  logic [15:0] i_completed_count,
    // result beat
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [11:0] o_frag_handle,
    output logic [1:0]  o_pb_flag,
    output logic [15:0] o_frag_length,
    output logic        o_pool,
    output logic [2:0]  o_status,
    output logic [15:0] o_acl_credits_left,
    output logic [7:0]  o_le_credits_left,
    output logic        o_last
);
    import acfs_pkg::*;

    // table slot index, ring pointer, queue fill and fragment count widths
    localparam int AW   = (MAX_CONNECTIONS > 1) ? $clog2(MAX_CONNECTIONS) : 1;
    localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW   = $clog2(MAX_FRAGMENTS + 1);
    localparam int XW   = 17;
    localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_CONNECTIONS - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIND  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_SEND  = 4'd5;
    localparam logic [3:0] S_DR0   = 4'd6;
    localparam logic [3:0] S_DR1   = 4'd7;
    localparam logic [3:0] S_DR2   = 4'd8;
    localparam logic [3:0] S_PURGE = 4'd9;
    localparam logic [3:0] S_DISC  = 4'd10;
    localparam logic [3:0] S_STAT  = 4'd11;

    // ring pointer advance modulo the queue depth
    function automatic logic [PW-1:0] f_wrap(input logic [PW-1:0] a,
                                             input logic [CNTW-1:0] b);
        logic [CNTW:0] s;
        s = (CNTW+1)'(a) + (CNTW+1)'(b);
        if (s >= (CNTW+1)'(QUEUE_DEPTH)) begin
            s = s - (CNTW+1)'(QUEUE_DEPTH);
        end
        return s[PW-1:0];
    endfunction

    logic [3:0]      r_state;

    // latched input beat
    logic [1:0]      r_act;
    logic [11:0]     r_h;
    logic            r_tr;
    logic [15:0]     r_plen;
    logic            r_fl;
    logic [15:0]     r_cc;

    // configuration
    logic [15:0]     r_acl_frame;
    logic [15:0]     r_le_frame;
    logic [7:0]      r_le_total;

    // credit pools
    logic [15:0]     r_acl_cr, n_acl_cr;
    logic [7:0]      r_le_cr, n_le_cr;

    // queue ring state per pool
    logic [PW-1:0]   r_head [2];
    logic [CNTW-1:0] r_qcnt [2];

    // table valid bits and scan
    logic [MAX_CONNECTIONS-1:0] r_valid;
    logic [AW-1:0]   r_scan;
    logic            r_pend;
    logic [AW-1:0]   r_pidx;
    logic            r_found;
    logic [AW-1:0]   r_slot;
    logic            r_free_ok;
    logic [AW-1:0]   r_free;
    t_conn           r_ent;

    // send and drain bookkeeping
    logic            r_pool;
    logic [15:0]     r_frame;
    logic [15:0]     r_rem;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_rel;
    logic [CW-1:0]   r_i;
    logic [2:0]      r_status;
    logic            r_spool;
    logic [5:0]      r_k;
    t_frag           r_qe_frag;
    logic [AW-1:0]   r_qe_slot;

    // purge pass
    logic            r_pp;
    logic [CNTW-1:0] r_rd;
    logic [CNTW-1:0] r_wr;

    // result register
    logic            r_ov;
    logic            r_o_kind;
    logic [11:0]     r_o_handle;
    logic [1:0]      r_o_pb;
    logic [15:0]     r_o_len;
    logic            r_o_pool;
    logic [2:0]      r_o_status;
    logic [15:0]     r_o_acl;
    logic [7:0]      r_o_le;
    logic            r_o_last;

    // memory ports
    logic            cm_we, cm_re;
    logic [AW-1:0]   cm_waddr, cm_raddr;
    t_conn           cm_wdata, cm_rdata;
    logic            qm_we, qm_re, qm_wpool, qm_rpool;
    logic [PW-1:0]   qm_wptr, qm_rptr;
    t_frag           qm_wfrag, qm_rfrag;
    logic [AW-1:0]   qm_wslot, qm_rslot;

    // emit request for the result register
    logic            out_free;
    logic            emit;
    t_frag           e_frag;
    logic            e_kind, e_pool, e_last;
    logic [2:0]      e_status;

    // derived control
    logic            hit;
    logic            le_on;
    logic            cur_pool;
    logic [15:0]     cur_frame;
    logic            cr_nz;
    logic            dr_go;
    logic            send_rel;
    logic            send_go;
    logic [CW-1:0]   cnt_n;
    logic [15:0]     send_len;
    logic [1:0]      send_pb;
    logic [XW-1:0]   chk_cr, chk_cnt, chk_rel, chk_need, chk_free;

    acfs_conn_mem #(
        .DEPTH (MAX_CONNECTIONS),
        .AW    (AW)
    ) u_conn_mem (
        .i_clk   (i_clk),
        .i_we    (cm_we),
        .i_waddr (cm_waddr),
        .i_wdata (cm_wdata),
        .i_re    (cm_re),
        .i_raddr (cm_raddr),
        .o_rdata (cm_rdata)
    );

    acfs_queue_mem #(
        .DEPTH (QUEUE_DEPTH),
        .PW    (PW),
        .SW    (AW)
    ) u_queue_mem (
        .i_clk   (i_clk),
        .i_we    (qm_we),
        .i_wpool (qm_wpool),
        .i_wptr  (qm_wptr),
        .i_wfrag (qm_wfrag),
        .i_wslot (qm_wslot),
        .i_re    (qm_re),
        .i_rpool (qm_rpool),
        .i_rptr  (qm_rptr),
        .o_rfrag (qm_rfrag),
        .o_rslot (qm_rslot)
    );

    assign out_free  = !r_ov || i_out_ready;
    assign le_on     = (r_le_total != 8'd0);
    // pool of the looked-up connection; unknown handles use the classic pool
    assign cur_pool  = r_found && r_ent.transport && le_on;
    assign cur_frame = cur_pool ? r_le_frame : r_acl_frame;
    assign hit       = r_pend && r_valid[r_pidx] && (cm_rdata.handle == r_h);
    assign cr_nz     = r_pool ? (r_le_cr != 8'd0) : (r_acl_cr != 16'd0);
    assign dr_go     = (r_k != DRAIN_MAX) && cr_nz && (r_qcnt[r_pool] != '0);
    assign cnt_n     = r_cnt + CW'(1);

    // fragments below the release count go out now, the rest are queued
    assign send_rel  = (r_i < r_rel);
    assign send_go   = !send_rel || out_free;
    assign send_len  = (r_i == r_count - CW'(1)) ? r_rem : r_frame;
    assign send_pb   = (r_i == '0) ? (r_fl ? PB_FIRST_FL : PB_FIRST_NF) : PB_CONT;

    // release count and queue room check
    assign chk_cr    = r_pool ? XW'(r_le_cr) : XW'(r_acl_cr);
    assign chk_cnt   = XW'(r_count);
    assign chk_rel   = (chk_cr < chk_cnt) ? chk_cr : chk_cnt;
    assign chk_need  = chk_cnt - chk_rel;
    assign chk_free  = XW'(QUEUE_DEPTH) - XW'(r_qcnt[r_pool]);

    always_comb begin
        cm_we     = 1'b0;
        cm_waddr  = r_slot;
        cm_wdata  = r_ent;
        cm_re     = 1'b0;
        cm_raddr  = r_scan;
        qm_we     = 1'b0;
        qm_wpool  = r_pool;
        qm_wptr   = f_wrap(r_head[r_pool], r_qcnt[r_pool]);
        qm_wfrag  = '{handle: r_h, pb: send_pb, len: send_len};
        qm_wslot  = r_slot;
        qm_re     = 1'b0;
        qm_rpool  = r_pool;
        qm_rptr   = r_head[r_pool];
        emit      = 1'b0;
        e_frag    = '{handle: r_h, pb: PB_FIRST_NF, len: 16'd0};
        e_kind    = KIND_STATUS;
        e_pool    = r_spool;
        e_status  = r_status;
        e_last    = 1'b1;
        n_acl_cr  = r_acl_cr;
        n_le_cr   = r_le_cr;

        unique case (r_state)
            S_FIND: begin
                cm_re    = 1'b1;
                cm_raddr = r_scan;
            end
            S_DISP: begin
                if (r_act == ACT_CONNECT) begin
                    // existing handle keeps its outstanding count
                    if (r_found) begin
                        cm_we    = 1'b1;
                        cm_waddr = r_slot;
                        cm_wdata = '{handle: r_h, transport: r_tr,
                                     outstanding: r_ent.outstanding};
                    end else if (r_free_ok) begin
                        cm_we    = 1'b1;
                        cm_waddr = r_free;
                        cm_wdata = '{handle: r_h, transport: r_tr, outstanding: 16'd0};
                    end
                end else if (r_found && r_act == ACT_COMPLETE) begin
                    if (cur_pool) begin
                        n_le_cr = f_add8_sat(r_le_cr, r_cc);
                    end else begin
                        n_acl_cr = f_add16_sat(r_acl_cr, r_cc);
                    end
                    cm_we    = 1'b1;
                    cm_waddr = r_slot;
                    cm_wdata = '{handle: r_ent.handle, transport: r_ent.transport,
                                 outstanding: (r_ent.outstanding > r_cc) ?
                                              (r_ent.outstanding - r_cc) : 16'd0};
                end
            end
            S_SEND: begin
                if (r_i < r_count) begin
                    if (send_rel) begin
                        if (out_free) begin
                            emit     = 1'b1;
                            e_kind   = KIND_FRAG;
                            e_frag   = '{handle: r_h, pb: send_pb, len: send_len};
                            e_pool   = r_pool;
                            e_status = ST_OK;
                            e_last   = 1'b0;
                            if (r_pool) begin
                                n_le_cr = r_le_cr - 8'd1;
                            end else begin
                                n_acl_cr = r_acl_cr - 16'd1;
                            end
                        end
                    end else begin
                        qm_we = 1'b1;
                    end
                end else begin
                    // released fragments all count as outstanding at once
                    cm_we    = 1'b1;
                    cm_waddr = r_slot;
                    cm_wdata = '{handle: r_ent.handle, transport: r_ent.transport,
                                 outstanding: f_add16_sat(r_ent.outstanding, 16'(r_rel))};
                end
            end
            S_DR0: begin
                if (dr_go) begin
                    qm_re    = 1'b1;
                    qm_rpool = r_pool;
                    qm_rptr  = r_head[r_pool];
                end
            end
            S_DR1: begin
                // queue entry carries its table slot, so no handle search here
                cm_re    = 1'b1;
                cm_raddr = qm_rslot;
            end
            S_DR2: begin
                if (out_free) begin
                    cm_we    = 1'b1;
                    cm_waddr = r_qe_slot;
                    cm_wdata = '{handle: cm_rdata.handle, transport: cm_rdata.transport,
                                 outstanding: f_add16_sat(cm_rdata.outstanding, 16'd1)};
                    emit     = 1'b1;
                    e_kind   = KIND_FRAG;
                    e_frag   = r_qe_frag;
                    e_pool   = r_pool;
                    e_status = ST_OK;
                    e_last   = 1'b0;
                    if (r_pool) begin
                        n_le_cr = r_le_cr - 8'd1;
                    end else begin
                        n_acl_cr = r_acl_cr - 16'd1;
                    end
                end
            end
            S_PURGE: begin
                // read runs ahead of the compacting write
                qm_rpool = r_pp;
                qm_rptr  = f_wrap(r_head[r_pp], r_rd);
                qm_re    = (r_rd < r_qcnt[r_pp]);
                qm_wpool = r_pp;
                qm_wptr  = f_wrap(r_head[r_pp], r_wr);
                qm_wfrag = qm_rfrag;
                qm_wslot = qm_rslot;
                qm_we    = r_pend && (qm_rfrag.handle != r_h);
            end
            S_DISC: begin
                if (r_pool) begin
                    n_le_cr = f_add8_sat(r_le_cr, r_ent.outstanding);
                end else begin
                    n_acl_cr = f_add16_sat(r_acl_cr, r_ent.outstanding);
                end
            end
            S_STAT: begin
                emit = out_free;
            end
            default: begin
            end
        endcase

        // a total write reloads its pool
        if (i_cfg_we && i_cfg_idx == REG_ACL_TOTAL) begin
            n_acl_cr = i_cfg_data;
        end
        if (i_cfg_we && i_cfg_idx == REG_LE_TOTAL) begin
            n_le_cr = i_cfg_data[7:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_acl_cr    <= 16'd0;
            r_le_cr     <= 8'd0;
            r_acl_frame <= 16'd0;
            r_le_frame  <= 16'd0;
            r_le_total  <= 8'd0;
            r_head[0]   <= '0;
            r_head[1]   <= '0;
            r_qcnt[0]   <= '0;
            r_qcnt[1]   <= '0;
            r_pend      <= 1'b0;
        end else begin
            r_acl_cr <= n_acl_cr;
            r_le_cr  <= n_le_cr;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_ACL_FRAME: r_acl_frame <= i_cfg_data;
                    REG_LE_FRAME:  r_le_frame  <= i_cfg_data;
                    REG_LE_TOTAL:  r_le_total  <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_act     <= i_action;
                        r_h       <= i_handle;
                        r_tr      <= i_transport;
                        r_plen    <= i_payload_length;
                        r_fl      <= i_flushable;
                        r_cc      <= i_completed_count;
                        r_scan    <= '0;
                        r_pend    <= 1'b0;
                        r_found   <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_state   <= S_FIND;
                    end
                end
                S_FIND: begin
                    r_pend <= 1'b1;
                    r_pidx <= r_scan;
                    if (r_scan != LAST_SLOT) begin
                        r_scan <= r_scan + AW'(1);
                    end
                    if (r_pend) begin
                        if (hit) begin
                            r_found <= 1'b1;
                            r_slot  <= r_pidx;
                            r_ent   <= cm_rdata;
                            r_state <= S_DISP;
                        end else begin
                            // first free slot, for a connect to a new handle
                            if (!r_valid[r_pidx] && !r_free_ok) begin
                                r_free_ok <= 1'b1;
                                r_free    <= r_pidx;
                            end
                            if (r_pidx == LAST_SLOT) begin
                                r_state <= S_DISP;
                            end
                        end
                    end
                end
                S_DISP: begin
                    r_pend <= 1'b0;
                    r_pool <= cur_pool;
                    if (r_act == ACT_CONNECT) begin
                        r_state <= S_STAT;
                        if (r_found || r_free_ok) begin
                            r_status <= ST_OK;
                            r_spool  <= r_tr && le_on;
                            if (!r_found) begin
                                r_valid[r_free] <= 1'b1;
                            end
                        end else begin
                            r_status <= ST_TABLE_FULL;
                            r_spool  <= 1'b0;
                        end
                    end else if (!r_found) begin
                        r_status <= ST_UNKNOWN;
                        r_spool  <= cur_pool;
                        r_state  <= S_STAT;
                    end else begin
                        r_spool <= cur_pool;
                        unique case (r_act)
                            ACT_SEND: begin
                                r_frame <= cur_frame;
                                if (r_plen <= cur_frame) begin
                                    r_status <= ST_OK;
                                    r_count  <= CW'(1);
                                    r_state  <= S_CHK;
                                end else if (cur_frame == 16'd0) begin
                                    r_status <= ST_ZERO_FRAME;
                                    r_state  <= S_STAT;
                                end else begin
                                    r_status <= ST_OK;
                                    r_rem    <= r_plen;
                                    r_cnt    <= '0;
                                    r_state  <= S_DIV;
                                end
                            end
                            ACT_COMPLETE: begin
                                r_status <= ST_OK;
                                r_k      <= 6'd0;
                                r_state  <= S_DR0;
                            end
                            ACT_DISCONNECT: begin
                                r_status <= ST_OK;
                                r_pp     <= 1'b0;
                                r_rd     <= '0;
                                r_wr     <= '0;
                                r_state  <= S_PURGE;
                            end
                            default: begin
                                r_status <= ST_OK;
                                r_state  <= S_STAT;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    // fragment count by repeated subtraction of the frame length
                    if (r_rem <= r_frame) begin
                        r_count <= cnt_n;
                        r_state <= S_CHK;
                    end else if (cnt_n >= CW'(MAX_FRAGMENTS)) begin
                        r_status <= ST_TOO_MANY;
                        r_state  <= S_STAT;
                    end else begin
                        r_rem <= r_rem - r_frame;
                        r_cnt <= cnt_n;
                    end
                end
                S_CHK: begin
                    if (chk_need > chk_free) begin
                        r_status <= ST_QUEUE_OVF;
                        r_state  <= S_STAT;
                    end else begin
                        r_rel   <= chk_rel[CW-1:0];
                        r_i     <= '0;
                        r_rem   <= r_plen;
                        r_state <= S_SEND;
                    end
                end
                S_SEND: begin
                    if (r_i < r_count) begin
                        if (send_go) begin
                            r_i   <= r_i + CW'(1);
                            r_rem <= r_rem - r_frame;
                            if (!send_rel) begin
                                r_qcnt[r_pool] <= r_qcnt[r_pool] + CNTW'(1);
                            end
                        end
                    end else begin
                        r_state <= S_STAT;
                    end
                end
                S_DR0: begin
                    r_state <= dr_go ? S_DR1 : S_STAT;
                end
                S_DR1: begin
                    r_qe_frag <= qm_rfrag;
                    r_qe_slot <= qm_rslot;
                    r_state   <= S_DR2;
                end
                S_DR2: begin
                    if (out_free) begin
                        r_head[r_pool] <= f_wrap(r_head[r_pool], CNTW'(1));
                        r_qcnt[r_pool] <= r_qcnt[r_pool] - CNTW'(1);
                        r_k            <= r_k + 6'd1;
                        r_state        <= S_DR0;
                    end
                end
                S_PURGE: begin
                    r_pend <= qm_re;
                    if (qm_re) begin
                        r_rd <= r_rd + CNTW'(1);
                    end
                    if (qm_we) begin
                        r_wr <= r_wr + CNTW'(1);
                    end
                    if (!qm_re && !r_pend) begin
                        r_qcnt[r_pp] <= r_wr;
                        r_rd         <= '0;
                        r_wr         <= '0;
                        if (r_pp) begin
                            r_state <= S_DISC;
                        end else begin
                            r_pp <= 1'b1;
                        end
                    end
                end
                S_DISC: begin
                    r_valid[r_slot] <= 1'b0;
                    r_state         <= S_STAT;
                end
                S_STAT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result register: a new beat loads as the old one leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_kind   <= e_kind;
            r_o_handle <= e_frag.handle;
            r_o_pb     <= e_frag.pb;
            r_o_len    <= e_frag.len;
            r_o_pool   <= e_pool;
            r_o_status <= e_status;
            r_o_acl    <= n_acl_cr;
            r_o_le     <= n_le_cr;
            r_o_last   <= e_last;
        end
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_ov;
    assign o_kind             = r_o_kind;
    assign o_frag_handle      = r_o_handle;
    assign o_pb_flag          = r_o_pb;
    assign o_frag_length      = r_o_len;
    assign o_pool             = r_o_pool;
    assign o_status           = r_o_status;
    assign o_acl_credits_left = r_o_acl;
    assign o_le_credits_left  = r_o_le;
    assign o_last             = r_o_last;

    // queue fill never passes the depth
    a_qcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_qcnt[0] <= CNTW'(QUEUE_DEPTH)) && (r_qcnt[1] <= CNTW'(QUEUE_DEPTH)))
        else $error("pending queue count beyond depth");

    // only the status beat closes an item
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind == o_last))
        else $error("last flag not on status beat");

    // fragment beats carry ok status
    a_frag_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_FRAG) |-> (o_status == ST_OK))
        else $error("fragment beat with error status");

    // le credits stay at zero while le shares the classic pool
    a_le_shared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_le_total == 8'd0) |-> (r_le_cr == 8'd0))
        else $error("le credits while le pool disabled");

endmodule
